[design/lzg_pkg.sv]
package lzg_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_SHIFT
  } lzg_state_e;

  localparam int unsigned CfgW   = 5;
  localparam int unsigned LitW   = 8;
  localparam int unsigned DistW  = 11;
  localparam int unsigned LenW   = 5;
  localparam logic [CfgW-1:0] MinLenRst = CfgW'(3);

endpackage

[design/lzg_history.sv]
module lzg_history
  import lzg_pkg::*;
#(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/lzg_cell.sv]
module lzg_cell
  import lzg_pkg::*;
#(
  parameter int unsigned Idx = 0,
  parameter int unsigned LW  = 5,
  parameter int unsigned DW  = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    strm_i,
  input  logic [LW-1:0] la_cnt_i,
  input  logic          load_i,
  input  logic [7:0]    load_data_i,
  input  logic          shift_i,
  input  logic [7:0]    next_byte_i,
  output logic [7:0]    byte_o,
  input  logic          cand_valid_i,
  input  logic [LW-1:0] cand_len_i,
  input  logic [DW-1:0] cand_dist_i,
  output logic          cand_valid_o,
  output logic [LW-1:0] cand_len_o,
  output logic [DW-1:0] cand_dist_o
);

  logic [7:0]    byte_q;
  logic          valid_q;
  logic [LW-1:0] len_q, len_d;
  logic [DW-1:0] dist_q;
  logic          hit;

  // candidate still running through all earlier cells and this byte agrees
  assign hit = (cand_len_i == LW'(Idx)) && (LW'(Idx) < la_cnt_i) && (byte_q == strm_i);
  assign len_d = hit ? LW'(Idx + 1) : cand_len_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= load_data_i;
    end else if (shift_i) begin
      byte_q <= next_byte_i;
    end
    len_q  <= len_d;
    dist_q <= cand_dist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cand_valid_i;
    end
  end

  assign byte_o       = byte_q;
  assign cand_valid_o = valid_q;
  assign cand_len_o   = len_q;
  assign cand_dist_o  = dist_q;

endmodule

[design/lz77_greedy_encoder.sv]
// Data beat that does not fill the lookahead: taken while idle, no token.
// Each token: a search that streams the history RAM one byte a cycle through
// a chain of MAX_MATCH compare cells, then an emit state (held while the
// output stalls) and a shift state that consumes the token's bytes.
// Reset clears position, counts and control; history RAM is not cleared.
module lz77_greedy_encoder
  import lzg_pkg::*;
#(
  parameter int unsigned WINDOW      = 1024,
  parameter int unsigned MAX_MATCH   = 16,
  parameter int unsigned STORE_DEPTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [LitW-1:0]    data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               is_match_o,
  output logic [LitW-1:0]    literal_o,
  output logic [DistW-1:0]   distance_o,
  output logic [LenW-1:0]    match_length_o,
  output logic               last_o
);

  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned LW   = $clog2(MAX_MATCH + 1);
  localparam int unsigned HW   = $clog2(WINDOW + 1);
  localparam int unsigned CNTW = $clog2(WINDOW + MAX_MATCH + 3);
  localparam int unsigned CMPW = (LW > CfgW) ? LW : CfgW;

  lzg_state_e state_q, state_d;

  logic [AW-1:0]   cp_q, cp_d;
  logic [LW-1:0]   la_q, la_d;
  logic [HW-1:0]   hc_q, hc_d;
  logic            flush_q, flush_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   raddr_q, raddr_d;
  logic [LW-1:0]   shcnt_q, shcnt_d;
  logic [CfgW-1:0] min_len_q;
  logic            tag_inj_q;
  logic [HW-1:0]   tag_dist_q;
  logic [LW-1:0]   best_len_q;
  logic [HW-1:0]   best_dist_q;
  logic            best_clr;

  logic            in_acc, out_acc;
  logic            wr_en;
  logic [AW-1:0]   waddr;
  logic [7:0]      rdata;
  logic            shift_en;
  logic [LW-1:0]   n_tok;
  logic [CfgW-1:0] need;
  logic            qualify;
  logic [AW-1:0]   start_addr;

  logic [7:0]    cell_byte [MAX_MATCH];
  logic          lk_valid  [MAX_MATCH+1];
  logic [LW-1:0] lk_len    [MAX_MATCH+1];
  logic [HW-1:0] lk_dist   [MAX_MATCH+1];

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + b;
    if (s >= (AW+1)'(STORE_DEPTH)) begin
      s = s - (AW+1)'(STORE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  assign wr_en = in_acc && !kind_i && (la_q < LW'(MAX_MATCH));
  assign waddr = ring_add(cp_q, (AW+1)'(la_q));

  assign start_addr = (cp_q >= AW'(hc_q)) ? (cp_q - AW'(hc_q))
                                          : AW'((AW+1)'(cp_q) + (AW+1)'(STORE_DEPTH)
                                                - (AW+1)'(hc_q));

  assign n_tok = (best_len_q != '0) ? best_len_q : LW'(1);
  assign need  = (min_len_q == '0) ? CfgW'(1) : min_len_q;

  lzg_history #(
    .Depth (STORE_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  assign lk_valid[0] = tag_inj_q;
  assign lk_len[0]   = '0;
  assign lk_dist[0]  = tag_dist_q;

  for (genvar j = 0; j < MAX_MATCH; j++) begin : g_cell
    logic [7:0] nb;
    if (j == MAX_MATCH - 1) begin : g_end
      assign nb = 8'h00;
    end else begin : g_mid
      assign nb = cell_byte[j+1];
    end
    lzg_cell #(
      .Idx (j),
      .LW  (LW),
      .DW  (HW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .strm_i       (rdata),
      .la_cnt_i     (la_q),
      .load_i       (wr_en && (la_q == LW'(j))),
      .load_data_i  (data_byte_i),
      .shift_i      (shift_en),
      .next_byte_i  (nb),
      .byte_o       (cell_byte[j]),
      .cand_valid_i (lk_valid[j]),
      .cand_len_i   (lk_len[j]),
      .cand_dist_i  (lk_dist[j]),
      .cand_valid_o (lk_valid[j+1]),
      .cand_len_o   (lk_len[j+1]),
      .cand_dist_o  (lk_dist[j+1])
    );
  end

  // strictly longer only: oldest candidate arrives first and keeps ties
  assign qualify = lk_valid[MAX_MATCH]
                && (CMPW'(lk_len[MAX_MATCH]) >= CMPW'(need))
                && (lk_len[MAX_MATCH] > best_len_q);

  always_comb begin
    logic [HW:0] hsum;
    state_d  = state_q;
    cp_d     = cp_q;
    la_d     = la_q;
    hc_d     = hc_q;
    flush_d  = flush_q;
    cnt_d    = cnt_q;
    raddr_d  = raddr_q;
    shcnt_d  = shcnt_q;
    shift_en = 1'b0;
    best_clr = 1'b0;
    hsum     = (HW+1)'(hc_q) + (HW+1)'(n_tok);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!kind_i) begin
            flush_d = 1'b0;
            if (wr_en) begin
              la_d = la_q + LW'(1);
            end
            if ((wr_en && (la_q + LW'(1) == LW'(MAX_MATCH))) || !wr_en) begin
              state_d  = ST_SEARCH;
              cnt_d    = '0;
              raddr_d  = start_addr;
              best_clr = 1'b1;
            end
          end else if (la_q != '0) begin
            flush_d  = 1'b1;
            state_d  = ST_SEARCH;
            cnt_d    = '0;
            raddr_d  = start_addr;
            best_clr = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cnt_d   = cnt_q + CNTW'(1);
        raddr_d = ring_add(raddr_q, (AW+1)'(1));
        if (cnt_q == CNTW'(hc_q) + CNTW'(MAX_MATCH + 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          cp_d    = ring_add(cp_q, (AW+1)'(n_tok));
          la_d    = la_q - n_tok;
          hc_d    = (hsum > (HW+1)'(WINDOW)) ? HW'(WINDOW) : hsum[HW-1:0];
          shcnt_d = n_tok;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        shift_en = 1'b1;
        shcnt_d  = shcnt_q - LW'(1);
        if (shcnt_q == LW'(1)) begin
          if (flush_q && (la_q != '0)) begin
            state_d  = ST_SEARCH;
            cnt_d    = '0;
            raddr_d  = start_addr;
            best_clr = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cp_q      <= '0;
      la_q      <= '0;
      hc_q      <= '0;
      flush_q   <= 1'b0;
      cnt_q     <= '0;
      raddr_q   <= '0;
      shcnt_q   <= '0;
      min_len_q <= MinLenRst;
      tag_inj_q <= 1'b0;
      best_len_q <= '0;
    end else begin
      state_q <= state_d;
      cp_q    <= cp_d;
      la_q    <= la_d;
      hc_q    <= hc_d;
      flush_q <= flush_d;
      cnt_q   <= cnt_d;
      raddr_q <= raddr_d;
      shcnt_q <= shcnt_d;
      if (cfg_we_i) begin
        min_len_q <= cfg_wdata_i;
      end
      // a candidate starts at every history byte, none inside the lookahead
      tag_inj_q <= (state_q == ST_SEARCH) && (cnt_q < CNTW'(hc_q));
      if (best_clr) begin
        best_len_q <= '0;
      end else if (qualify) begin
        best_len_q <= lk_len[MAX_MATCH];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_dist_q <= HW'(CNTW'(hc_q) - cnt_q);
    if (qualify && !best_clr) begin
      best_dist_q <= lk_dist[MAX_MATCH];
    end
  end

  assign is_match_o     = (best_len_q != '0);
  assign literal_o      = is_match_o ? '0 : cell_byte[0];
  assign distance_o     = is_match_o ? DistW'(best_dist_q) : '0;
  assign match_length_o = is_match_o ? LenW'(best_len_q) : '0;
  assign last_o         = !flush_q || (la_q == n_tok);

  a_la_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    la_q <= LW'(MAX_MATCH))
    else $error("lookahead count overrun");

  a_hc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= HW'(WINDOW))
    else $error("history count overrun");

  a_match_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_match_o) |-> (best_len_q <= la_q && best_dist_q != '0))
    else $error("match token longer than lookahead");

  a_shift_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> (state_q == ST_SHIFT && shcnt_q != '0))
    else $error("token beat without consume");

endmodule
